FILE: design/sparse_coverage_sliding_window_core_macros.svh
// Assertion macros for the sparse coverage sliding window core.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef SPARSE_COVERAGE_SLIDING_WINDOW_CORE_MACROS_SVH
`define SPARSE_COVERAGE_SLIDING_WINDOW_CORE_MACROS_SVH

// same-cycle implication
`define SCSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCSW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/scsw_pkg.sv
// Shared types and constants for the sparse coverage sliding window core.
// No dependencies.
`default_nettype none

package scsw_pkg;

  localparam int MAX_WINDOW_DEF = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam int CFG_W    = 6;
  localparam int CHR_W    = 8;
  localparam int POS_W    = 32;
  localparam int CNT_IN_W = 16;
  localparam int SUM_W    = 22;

  localparam logic [CFG_W-1:0] LEN_RESET = 6'd32;
  localparam logic [SUM_W-1:0] SUM_MAX   = '1;

  typedef struct packed {
    logic                func;
    logic [CHR_W-1:0]    chromosome;
    logic [POS_W-1:0]    position;
    logic [CNT_IN_W-1:0] plus_count;
    logic [CNT_IN_W-1:0] minus_count;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] window_start;
    logic [CHR_W-1:0] window_chromosome;
    logic [SUM_W-1:0] plus_sum;
    logic [SUM_W-1:0] minus_sum;
    logic             last_of_run;
  } out_word_t;

endpackage

`default_nettype wire

FILE: design/sparse_coverage_sliding_window_core.sv
// Sparse coverage sliding window core: ring of per-position counts in one
// synchronous RAM, running strand totals, registered result word.
// Sequence: a record stored at once is accepted with its RAM read, then written back;
// else it is accepted, windows are emitted and slid, and it is read, then written to store.
// Throughput: one word in flight, as in_stall is high outside idle; output stalls hold emits.
// Reset: synchronous; per-entry valid bits make the RAM read as zero.
`default_nettype none
`include "sparse_coverage_sliding_window_core_macros.svh"

module sparse_coverage_sliding_window_core
  import scsw_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_word_t         in_word,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_word_t             out_word,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  localparam int SLOT_W    = $clog2(MAX_WINDOW);
  localparam int TOT_W     = COUNT_BITS + $clog2(MAX_WINDOW);
  localparam int CMP_W     = (TOT_W > SUM_W) ? TOT_W : SUM_W;
  localparam int CNT_EXT_W = (COUNT_BITS > CNT_IN_W) ? COUNT_BITS : CNT_IN_W;
  localparam int ENT_W     = 2 * COUNT_BITS;

  typedef enum logic [2:0] {ST_IDLE, ST_PUT_RD, ST_PUT_WR, ST_EMIT, ST_SL_WR} state_t;

  function automatic logic [COUNT_BITS-1:0] cnt_of(input logic [CNT_IN_W-1:0] x);
    logic [CNT_EXT_W-1:0] e;
    e = CNT_EXT_W'(x);
    return e[COUNT_BITS-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] h,
                                                 input logic [SLOT_W-1:0] off);
    logic [SLOT_W:0] s;
    s = {1'b0, h} + {1'b0, off};
    if (s >= (SLOT_W+1)'(MAX_WINDOW)) s = s - (SLOT_W+1)'(MAX_WINDOW);
    return s[SLOT_W-1:0];
  endfunction

  function automatic logic fits_at(input logic [CHR_W-1:0] c, input logic [POS_W-1:0] p,
                                   input logic [CHR_W-1:0] wc, input logic [POS_W-1:0] ws,
                                   input logic [CFG_W-1:0] len);
    return (c == wc) && (p >= ws) &&
           ({1'b0, p} < ({1'b0, ws} + (POS_W+1)'(len)));
  endfunction

  function automatic logic [POS_W-1:0] jstart(input logic [POS_W-1:0] p,
                                             input logic [CFG_W-1:0] l1);
    return (p >= POS_W'(l1)) ? p - POS_W'(l1) : '0;
  endfunction

  function automatic logic [SUM_W-1:0] sat(input logic [TOT_W-1:0] t);
    logic [CMP_W-1:0] e;
    e = CMP_W'(t);
    return (e > CMP_W'(SUM_MAX)) ? SUM_MAX : e[SUM_W-1:0];
  endfunction

  state_t                 state_r;
  in_word_t               word_r;
  logic [SLOT_W-1:0]      head_r;
  logic [SLOT_W-1:0]      slot_r;
  logic [POS_W-1:0]       start_r;
  logic [CHR_W-1:0]       chr_r;
  logic [TOT_W-1:0]       ptot_r;
  logic [TOT_W-1:0]       mtot_r;
  logic                   open_r;
  logic                   flush_r;
  logic                   fin_r;
  logic [CFG_W-1:0]       len_r;
  logic                   out_valid_r;
  out_word_t              out_word_r;

  logic [ENT_W-1:0]       mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  vld_r;
  logic [ENT_W-1:0]       rd_data_r;
  logic                   rd_vld_r;

  logic [CFG_W-1:0]       eff_len;
  logic [CFG_W-1:0]       len_m1;
  logic [POS_W-1:0]       fit_diff;
  logic [POS_W-1:0]       put_diff;
  logic [POS_W-1:0]       start_inc;
  logic [SLOT_W-1:0]      slot_jump;
  logic [SLOT_W-1:0]      slot_fit;
  logic [SLOT_W-1:0]      slot_put;
  logic [SLOT_W-1:0]      head_inc;
  logic [SLOT_W-1:0]      rd_addr;
  logic [SLOT_W-1:0]      wr_addr;
  logic                   wr_en;
  logic [ENT_W-1:0]       wr_data;
  logic [ENT_W-1:0]       old_ent;
  logic [COUNT_BITS-1:0]  new_p;
  logic [COUNT_BITS-1:0]  new_m;
  logic                   in_behind;
  logic                   in_fits;
  logic                   fit_nx;
  logic                   tot_zero;
  logic                   out_free;

  always_comb begin
    if (len_r == '0) begin
      eff_len = CFG_W'(1);
    end else if (len_r > CFG_W'(MAX_WINDOW)) begin
      eff_len = CFG_W'(MAX_WINDOW);
    end else begin
      eff_len = len_r;
    end
  end

  assign len_m1    = eff_len - CFG_W'(1);
  assign fit_diff  = in_word.position - start_r;
  assign put_diff  = word_r.position - start_r;
  assign start_inc = start_r + POS_W'(1);
  assign head_inc  = (head_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : head_r + SLOT_W'(1);

  assign slot_jump = slot_add(head_r, (in_word.position >= POS_W'(len_m1)) ?
                                      len_m1[SLOT_W-1:0] : in_word.position[SLOT_W-1:0]);
  assign slot_fit  = slot_add(head_r, fit_diff[SLOT_W-1:0]);
  assign slot_put  = slot_add(head_r, put_diff[SLOT_W-1:0]);

  assign in_behind = (in_word.chromosome == chr_r) && (in_word.position < start_r);
  assign in_fits   = fits_at(in_word.chromosome, in_word.position, chr_r, start_r, eff_len);
  assign fit_nx    = fits_at(word_r.chromosome, word_r.position, chr_r, start_inc, eff_len);
  assign tot_zero  = (ptot_r == '0) && (mtot_r == '0);
  assign out_free  = !out_valid_r || !out_stall;

  assign new_p   = cnt_of(word_r.plus_count);
  assign new_m   = cnt_of(word_r.minus_count);
  assign old_ent = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    unique case (state_r)
      ST_IDLE:   rd_addr = open_r ? slot_fit : slot_jump;
      ST_PUT_RD: rd_addr = slot_put;
      default:   rd_addr = head_r;
    endcase
  end

  assign wr_en   = (state_r == ST_PUT_WR) || (state_r == ST_SL_WR);
  assign wr_addr = (state_r == ST_SL_WR) ? head_r : slot_r;
  assign wr_data = (state_r == ST_SL_WR) ? '0 : {new_p, new_m};

  // ring RAM, one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      start_r     <= '0;
      chr_r       <= '0;
      ptot_r      <= '0;
      mtot_r      <= '0;
      open_r      <= 1'b0;
      flush_r     <= 1'b0;
      fin_r       <= 1'b0;
      len_r       <= LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            word_r <= in_word;
            if (in_word.func) begin
              if (open_r) begin
                flush_r <= 1'b1;
                state_r <= ST_EMIT;
              end
            end else if (!open_r) begin
              open_r  <= 1'b1;
              chr_r   <= in_word.chromosome;
              start_r <= jstart(in_word.position, len_m1);
              slot_r  <= slot_jump;
              state_r <= ST_PUT_WR;
            end else if (in_behind) begin
              state_r <= ST_IDLE;
            end else if (in_fits) begin
              slot_r  <= slot_fit;
              state_r <= ST_PUT_WR;
            end else begin
              flush_r <= 1'b0;
              state_r <= ST_EMIT;
            end
          end
        end
        ST_PUT_RD: begin
          slot_r  <= slot_put;
          state_r <= ST_PUT_WR;
        end
        ST_PUT_WR: begin
          ptot_r  <= ptot_r - TOT_W'(old_ent[ENT_W-1:COUNT_BITS]) + TOT_W'(new_p);
          mtot_r  <= mtot_r - TOT_W'(old_ent[COUNT_BITS-1:0]) + TOT_W'(new_m);
          state_r <= ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r                  <= 1'b1;
            out_word_r.window_start      <= start_r;
            out_word_r.window_chromosome <= chr_r;
            out_word_r.plus_sum          <= sat(ptot_r);
            out_word_r.minus_sum         <= sat(mtot_r);
            if (flush_r) begin
              out_word_r.last_of_run <= tot_zero;
              if (tot_zero) begin
                open_r  <= 1'b0;
                state_r <= ST_IDLE;
              end else begin
                state_r <= ST_SL_WR;
              end
            end else begin
              out_word_r.last_of_run <= tot_zero || fit_nx;
              if (tot_zero) begin
                chr_r   <= word_r.chromosome;
                start_r <= jstart(word_r.position, len_m1);
                state_r <= ST_PUT_RD;
              end else begin
                fin_r   <= fit_nx;
                state_r <= ST_SL_WR;
              end
            end
          end
        end
        ST_SL_WR: begin
          ptot_r  <= ptot_r - TOT_W'(old_ent[ENT_W-1:COUNT_BITS]);
          mtot_r  <= mtot_r - TOT_W'(old_ent[COUNT_BITS-1:0]);
          head_r  <= head_inc;
          start_r <= start_inc;
          state_r <= (!flush_r && fin_r) ? ST_PUT_RD : ST_EMIT;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `SCSW_ASSERT_IMP(a_closed_zero, !open_r, (ptot_r == '0) && (mtot_r == '0), "totals nonzero with no window open")
  `SCSW_ASSERT_IMP(a_put_open, state_r == ST_PUT_WR, open_r, "write back with no window open")
  `SCSW_ASSERT_IMP(a_emit_src, $rose(out_valid_r), $past(state_r == ST_EMIT), "result word loaded outside emit")
  `SCSW_ASSERT_NXT(a_head_hold, state_r != ST_SL_WR, $stable(head_r), "ring head moved without a slide")

endmodule

`default_nettype wire
